[hdl/mnb_pkg.sv]
package mnb_pkg;

  localparam int MAX_PAIRS_DEF   = 256;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH     = 9;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_S_NEXT,
    ST_S_KEY,
    ST_S_CMP,
    ST_S_PUT,
    ST_L_NEXT,
    ST_L_KEY,
    ST_L_PROBE,
    ST_L_TEST,
    ST_L_PUT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic s_rd;
    logic s_key;
    logic s_shift;
    logic s_put;
    logic l_init;
    logic l_rd;
    logic l_key;
    logic probe;
    logic test;
    logic l_put;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic i_done;
    logic key_first;
    logic j_one;
    logic lo_lt_hi;
    logic out_busy;
  } status_t;

endpackage

[hdl/mnb_if.sv]
interface mnb_pair_if #(
  parameter int COORD_WIDTH = mnb_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] north_pos;
  logic signed [COORD_WIDTH-1:0] south_pos;
  logic                          last_pair;

  modport source (output valid, north_pos, south_pos, last_pair, input ready);
  modport sink (input valid, north_pos, south_pos, last_pair, output ready);
endinterface

interface mnb_result_if;
  logic                              valid;
  logic                              ready;
  logic [mnb_pkg::COUNT_WIDTH-1:0]   bridge_count;
  logic                              overflow;

  modport source (output valid, bridge_count, overflow, input ready);
  modport sink (input valid, bridge_count, overflow, output ready);
endinterface

[hdl/mnb_datapath.sv]
module mnb_datapath #(
  parameter int MAX_PAIRS   = mnb_pkg::MAX_PAIRS_DEF,
  parameter int COORD_WIDTH = mnb_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mnb_pkg::cmd_t                   cmd_i,
  output mnb_pkg::status_t                status_o,
  input  logic signed [COORD_WIDTH-1:0]   north_i,
  input  logic signed [COORD_WIDTH-1:0]   south_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mnb_pkg::COUNT_WIDTH-1:0] bridge_count_o,
  output logic                            overflow_o
);

  localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int PW = 2 * COORD_WIDTH;

  logic [PW-1:0]          pair_mem [MAX_PAIRS];
  logic [COORD_WIDTH-1:0] tail_mem [MAX_PAIRS];

  logic [PW-1:0]          pair_rd_q, key_q;
  logic [COORD_WIDTH-1:0] tail_rd_q, sval_q;
  logic [CW-1:0]          cnt_q, i_q, j_q, len_q, lo_q, hi_q, mid_q;
  logic                   ovf_q;
  logic                   out_valid_q, out_ovf_q;
  logic [mnb_pkg::COUNT_WIDTH-1:0] out_count_q;

  logic          full;
  logic [AW-1:0] p_raddr, p_waddr;
  logic [PW-1:0] p_wdata;
  logic          p_we;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic signed [COORD_WIDTH-1:0] kn, ks, rn, rs;

  assign full    = (cnt_q == CW'(MAX_PAIRS));
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];
  assign kn      = key_q[PW-1:COORD_WIDTH];
  assign ks      = key_q[COORD_WIDTH-1:0];
  assign rn      = pair_rd_q[PW-1:COORD_WIDTH];
  assign rs      = pair_rd_q[COORD_WIDTH-1:0];

  always_comb begin
    p_we    = 1'b0;
    p_waddr = cnt_q[AW-1:0];
    p_wdata = {north_i, south_i};
    if (cmd_i.load && !full) begin
      p_we = 1'b1;
    end else if (cmd_i.s_shift) begin
      p_we    = 1'b1;
      p_waddr = j_q[AW-1:0];
      p_wdata = pair_rd_q;
    end else if (cmd_i.s_put) begin
      p_we    = 1'b1;
      p_waddr = j_q[AW-1:0];
      p_wdata = key_q;
    end
    p_raddr = i_q[AW-1:0];
    if (cmd_i.s_key) begin
      p_raddr = AW'(i_q - CW'(1));
    end else if (cmd_i.s_shift) begin
      p_raddr = AW'(j_q - CW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pair_mem[p_waddr] <= p_wdata;
    end
    pair_rd_q <= pair_mem[p_raddr];
    if (cmd_i.l_put) begin
      tail_mem[lo_q[AW-1:0]] <= sval_q;
    end
    tail_rd_q <= tail_mem[mid[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_count_q <= '0;
      i_q         <= '0;
      j_q         <= '0;
      len_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      key_q       <= '0;
      sval_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.sort_init) begin
        i_q <= CW'(1);
      end
      if (cmd_i.s_key) begin
        key_q <= pair_rd_q;
        j_q   <= i_q;
      end
      if (cmd_i.s_shift) begin
        j_q <= j_q - CW'(1);
      end
      if (cmd_i.s_put) begin
        i_q <= i_q + CW'(1);
      end
      if (cmd_i.l_init) begin
        i_q   <= '0;
        len_q <= '0;
      end
      if (cmd_i.l_key) begin
        sval_q <= pair_rd_q[COORD_WIDTH-1:0];
        lo_q   <= '0;
        hi_q   <= len_q;
      end
      if (cmd_i.probe) begin
        mid_q <= mid;
      end
      if (cmd_i.test) begin
        // first tail not below the value
        if ($signed(tail_rd_q) < $signed(sval_q)) begin
          lo_q <= mid_q + CW'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      if (cmd_i.l_put) begin
        i_q <= i_q + CW'(1);
        if (lo_q == len_q) begin
          len_q <= len_q + CW'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        out_count_q <= mnb_pkg::COUNT_WIDTH'(len_q);
        out_ovf_q   <= ovf_q;
        cnt_q       <= '0;
        ovf_q       <= 1'b0;
        len_q       <= '0;
      end
    end
  end

  assign status_o.i_done    = (i_q >= cnt_q);
  assign status_o.key_first = (kn == rn) ? (ks < rs) : (kn < rn);
  assign status_o.j_one     = (j_q == CW'(1));
  assign status_o.lo_lt_hi  = (lo_q < hi_q);
  assign status_o.out_busy  = out_valid_q;

  assign out_valid_o    = out_valid_q;
  assign bridge_count_o = out_count_q;
  assign overflow_o     = out_ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_PAIRS)) else $error("pair count beyond capacity");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= cnt_q) else $error("run length exceeds stored pairs");
  a_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q) else $error("search bounds crossed");
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q && cnt_q == '0 && !ovf_q)
    else $error("emit did not post word and clear set");

endmodule

[hdl/mnb_controller.sv]
module mnb_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  mnb_pkg::status_t  status_i,
  output mnb_pkg::cmd_t     cmd_o
);

  mnb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mnb_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mnb_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.sort_init = 1'b1;
            state_d         = mnb_pkg::ST_S_NEXT;
          end
        end
      end
      mnb_pkg::ST_S_NEXT: begin
        if (status_i.i_done) begin
          cmd_o.l_init = 1'b1;
          state_d      = mnb_pkg::ST_L_NEXT;
        end else begin
          cmd_o.s_rd = 1'b1;
          state_d    = mnb_pkg::ST_S_KEY;
        end
      end
      mnb_pkg::ST_S_KEY: begin
        cmd_o.s_key = 1'b1;
        state_d     = mnb_pkg::ST_S_CMP;
      end
      mnb_pkg::ST_S_CMP: begin
        if (status_i.key_first) begin
          cmd_o.s_shift = 1'b1;
          if (status_i.j_one) begin
            state_d = mnb_pkg::ST_S_PUT;
          end
        end else begin
          state_d = mnb_pkg::ST_S_PUT;
        end
      end
      mnb_pkg::ST_S_PUT: begin
        cmd_o.s_put = 1'b1;
        state_d     = mnb_pkg::ST_S_NEXT;
      end
      mnb_pkg::ST_L_NEXT: begin
        if (status_i.i_done) begin
          state_d = mnb_pkg::ST_EMIT;
        end else begin
          cmd_o.l_rd = 1'b1;
          state_d    = mnb_pkg::ST_L_KEY;
        end
      end
      mnb_pkg::ST_L_KEY: begin
        cmd_o.l_key = 1'b1;
        state_d     = mnb_pkg::ST_L_PROBE;
      end
      mnb_pkg::ST_L_PROBE: begin
        if (status_i.lo_lt_hi) begin
          cmd_o.probe = 1'b1;
          state_d     = mnb_pkg::ST_L_TEST;
        end else begin
          state_d = mnb_pkg::ST_L_PUT;
        end
      end
      mnb_pkg::ST_L_TEST: begin
        cmd_o.test = 1'b1;
        state_d    = mnb_pkg::ST_L_PROBE;
      end
      mnb_pkg::ST_L_PUT: begin
        cmd_o.l_put = 1'b1;
        state_d     = mnb_pkg::ST_L_NEXT;
      end
      mnb_pkg::ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = mnb_pkg::ST_LOAD;
        end
      end
      default: state_d = mnb_pkg::ST_LOAD;
    endcase
  end

  a_ready_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == mnb_pkg::ST_LOAD) else $error("ready outside load");
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_last_i |=> state_q == mnb_pkg::ST_S_NEXT)
    else $error("last word did not start sort");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !status_i.out_busy) else $error("emit over pending result");

endmodule

[hdl/max_nonoverlap_bridges_lis_unit.sv]
// Pairs load at one word per cycle while the set is open.
// After the last word: insertion sort reads each pair as a key, shifts the
// displaced entries up and puts the key in place, then the run search takes
// each pair in turn and binary-searches the tail memory for its place.
// One result per set; the next set may load while a result waits on the output.
// Reset (async, active low) empties the set; memories are not cleared.
module max_nonoverlap_bridges_lis_unit #(
  parameter int MAX_PAIRS   = mnb_pkg::MAX_PAIRS_DEF,
  parameter int COORD_WIDTH = mnb_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mnb_pair_if.sink     pair_i,
  mnb_result_if.source result_o
);

  mnb_pkg::cmd_t    cmd;
  mnb_pkg::status_t status;

  mnb_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pair_i.valid),
    .in_last_i  (pair_i.last_pair),
    .in_ready_o (pair_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mnb_datapath #(
    .MAX_PAIRS   (MAX_PAIRS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .north_i        (pair_i.north_pos),
    .south_i        (pair_i.south_pos),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .bridge_count_o (result_o.bridge_count),
    .overflow_o     (result_o.overflow)
  );

endmodule
